[design/fqbrr_pkg.sv]
// Shared types and codes for the four-queue burst round-robin core.
package fqbrr_pkg;

  localparam int LANE_W     = 2;
  localparam int ID_W       = 16;
  localparam int TIME_W     = 8;
  localparam int LIMIT_W    = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  typedef struct packed {
    logic [ID_W-1:0]   car_id;
    logic [TIME_W-1:0] hold_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_SERVE  = 1'b1
  } command_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BURST_LIMIT = 1'b0,
    REG_START_LANE  = 1'b1
  } cfg_reg_t;

endpackage

[design/four_queue_burst_round_robin_core.sv]
// Top level of the four-queue burst round-robin core.
//
// Input channel (in_valid/in_ready): each transfer is an arrive command, which
// pushes a car into the queue of its lane, or a serve command, which pops one
// car under a round-robin rotation with at most burst_limit cars per turn, a
// limit of 0 counting as 1. Result channel (out_valid/out_ready): exactly one
// result per input transfer, in order, in the cycle after the input transfer.
// Throughput is one item per cycle unless stalled: the lane choice and pointer
// update are one combinational pass into the state and result registers, and
// the queue entry comes from a RAM read in the same cycle, registered in the RAM.
// Configuration port: cfg_we with cfg_index 0 writes burst_limit, index 1
// writes start_lane, which also restarts the rotation at that lane.
// Reset empties all queues, sets burst_limit to 1 and the current lane to 0;
// the queue RAM is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds and in_ready is low
// until the result is taken; in_ready is high whenever the result register
// is empty or is being emptied in the same cycle.
module four_queue_burst_round_robin_core #(
  parameter int QUEUE_DEPTH = 16,
  parameter int LANE_COUNT  = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_command,
  input  logic [fqbrr_pkg::LANE_W-1:0]         in_arrive_lane,
  input  logic [fqbrr_pkg::ID_W-1:0]           in_car_id,
  input  logic [fqbrr_pkg::TIME_W-1:0]         in_hold_time,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [fqbrr_pkg::ID_W-1:0]           out_served_id,
  output logic [fqbrr_pkg::TIME_W-1:0]         out_served_time,
  output logic [fqbrr_pkg::LANE_W-1:0]         out_served_lane,
  output logic                                 out_turn_started,
  input  logic                                 cfg_we,
  input  logic [fqbrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fqbrr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LSEL_W    = $clog2(LANE_COUNT);
  localparam int ADDR_W    = LSEL_W + PTR_W;
  localparam int RAM_DEPTH = LANE_COUNT * (1 << PTR_W);
  localparam int LW        = fqbrr_pkg::LANE_W;

  logic [PTR_W-1:0]                 head_r [LANE_COUNT];
  logic [PTR_W-1:0]                 head_nxt [LANE_COUNT];
  logic [PTR_W-1:0]                 tail_r [LANE_COUNT];
  logic [PTR_W-1:0]                 tail_nxt [LANE_COUNT];
  logic [OCC_W-1:0]                 occ_r [LANE_COUNT];
  logic [OCC_W-1:0]                 occ_nxt [LANE_COUNT];
  logic [LW-1:0]                    cur_lane_r, cur_lane_nxt;
  logic [fqbrr_pkg::LIMIT_W-1:0]    served_r, served_nxt;
  logic                             turn_open_r, turn_open_nxt;
  logic [fqbrr_pkg::LIMIT_W-1:0]    burst_limit_r;
  logic                             out_valid_r;
  fqbrr_pkg::status_t               out_status_r, status_nxt;
  logic [LW-1:0]                    out_lane_r, lane_nxt;
  logic                             out_started_r, started_nxt;

  logic                             accept;
  logic [(1 << LW)-1:0]             busy_v;
  logic [fqbrr_pkg::LIMIT_W-1:0]    limit;
  logic                             cont;
  logic                             found;
  logic [LW-1:0]                    cand;
  logic [LW-1:0]                    sel_lane;
  logic [LW-1:0]                    pop_lane;
  logic [LSEL_W-1:0]                pop_idx;
  logic [LSEL_W-1:0]                arr_idx;
  logic                             arr_ok;
  logic                             do_push;
  logic                             do_pop;
  logic [ADDR_W-1:0]                waddr;
  logic [ADDR_W-1:0]                raddr;
  fqbrr_pkg::entry_t                wentry;
  fqbrr_pkg::entry_t                rentry;
  logic [fqbrr_pkg::ENTRY_W-1:0]    rdata;

  function automatic logic [LW-1:0] next_lane(input logic [LW-1:0] l);
    logic [LW:0] s;
    s = {1'b0, l} + (LW + 1)'(1);
    next_lane = (s >= (LW + 1)'(LANE_COUNT)) ? '0 : s[LW-1:0];
  endfunction

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [PTR_W-1:0] p);
    wrap_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    busy_v = '0;
    for (int i = 0; i < LANE_COUNT; i++) begin
      busy_v[i] = occ_r[i] != '0;
    end
  end

  // arrive
  assign arr_idx = in_arrive_lane[LSEL_W-1:0];
  assign arr_ok  = ({1'b0, in_arrive_lane} < (LW + 1)'(LANE_COUNT)) &&
                   (occ_r[arr_idx] < OCC_W'(QUEUE_DEPTH));

  // serve
  assign limit = (burst_limit_r == '0) ? fqbrr_pkg::LIMIT_W'(1) : burst_limit_r;
  assign cont  = turn_open_r && busy_v[cur_lane_r] && (served_r < limit);

  always_comb begin
    cand     = turn_open_r ? next_lane(cur_lane_r) : cur_lane_r;
    found    = 1'b0;
    sel_lane = '0;
    for (int k = 0; k < LANE_COUNT; k++) begin
      if (!found && busy_v[cand]) begin
        found    = 1'b1;
        sel_lane = cand;
      end
      cand = next_lane(cand);
    end
  end

  assign pop_lane = cont ? cur_lane_r : sel_lane;
  assign pop_idx  = pop_lane[LSEL_W-1:0];
  assign do_push  = accept && (in_command == fqbrr_pkg::CMD_ARRIVE) && arr_ok;
  assign do_pop   = accept && (in_command == fqbrr_pkg::CMD_SERVE) && (cont || found);

  assign waddr            = {arr_idx, tail_r[arr_idx]};
  assign raddr            = {pop_idx, head_r[pop_idx]};
  assign wentry.car_id    = in_car_id;
  assign wentry.hold_time = in_hold_time;

  fqbrr_ram #(
    .WIDTH(fqbrr_pkg::ENTRY_W),
    .DEPTH(RAM_DEPTH)
  ) u_queue_ram (
    .clk  (clk),
    .we   (do_push),
    .waddr(waddr),
    .wdata(wentry),
    .re   (do_pop),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    for (int i = 0; i < LANE_COUNT; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      occ_nxt[i]  = occ_r[i];
      if (do_push && (arr_idx == LSEL_W'(i))) begin
        tail_nxt[i] = wrap_ptr(tail_r[i]);
        occ_nxt[i]  = occ_r[i] + OCC_W'(1);
      end
      if (do_pop && (pop_idx == LSEL_W'(i))) begin
        head_nxt[i] = wrap_ptr(head_r[i]);
        occ_nxt[i]  = occ_r[i] - OCC_W'(1);
      end
    end
  end

  always_comb begin
    cur_lane_nxt  = cur_lane_r;
    served_nxt    = served_r;
    turn_open_nxt = turn_open_r;
    if (do_pop) begin
      if (cont) begin
        served_nxt = served_r + fqbrr_pkg::LIMIT_W'(1);
      end else begin
        cur_lane_nxt  = sel_lane;
        served_nxt    = fqbrr_pkg::LIMIT_W'(1);
        turn_open_nxt = 1'b1;
      end
    end
    if (cfg_we && (cfg_index == fqbrr_pkg::REG_START_LANE)) begin
      cur_lane_nxt  = cfg_wdata[LW-1:0];
      served_nxt    = '0;
      turn_open_nxt = 1'b0;
    end
  end

  always_comb begin
    lane_nxt    = '0;
    started_nxt = 1'b0;
    if (in_command == fqbrr_pkg::CMD_ARRIVE) begin
      status_nxt = arr_ok ? fqbrr_pkg::ST_ACCEPTED : fqbrr_pkg::ST_FULL;
    end else if (cont || found) begin
      status_nxt  = fqbrr_pkg::ST_SERVED;
      lane_nxt    = pop_lane;
      started_nxt = !cont;
    end else begin
      status_nxt = fqbrr_pkg::ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        occ_r[i]  <= '0;
      end
      cur_lane_r    <= '0;
      served_r      <= '0;
      turn_open_r   <= 1'b0;
      burst_limit_r <= fqbrr_pkg::LIMIT_W'(1);
      out_valid_r   <= 1'b0;
      out_status_r  <= fqbrr_pkg::ST_ACCEPTED;
      out_lane_r    <= '0;
      out_started_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      cur_lane_r  <= cur_lane_nxt;
      served_r    <= served_nxt;
      turn_open_r <= turn_open_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fqbrr_pkg::REG_BURST_LIMIT: begin
            burst_limit_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= status_nxt;
        out_lane_r    <= lane_nxt;
        out_started_r <= started_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign rentry           = rdata;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_served_lane  = out_lane_r;
  assign out_turn_started = out_started_r;
  assign out_served_id    = (out_status_r == fqbrr_pkg::ST_SERVED) ? rentry.car_id : '0;
  assign out_served_time  = (out_status_r == fqbrr_pkg::ST_SERVED) ? rentry.hold_time : '0;

endmodule

[design/fqbrr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fqbrr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/fqbrr_checker.sv]
// Port-level checker for the four-queue burst round-robin core, with its bind.
module fqbrr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       out_status,
  input logic [fqbrr_pkg::ID_W-1:0]       out_served_id,
  input logic [fqbrr_pkg::TIME_W-1:0]     out_served_time,
  input logic [fqbrr_pkg::LANE_W-1:0]     out_served_lane,
  input logic                             out_turn_started
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer in without a result in the next cycle");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled while result register is free");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_served_id) && $stable(out_served_time) &&
      $stable(out_served_lane) && $stable(out_turn_started))
    else $error("stalled result changed");

  a_zero_unless_served: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != fqbrr_pkg::ST_SERVED) |->
      out_served_id == '0 && out_served_time == '0 &&
      out_served_lane == '0 && !out_turn_started)
    else $error("served fields set on a result that is not a grant");

endmodule

bind four_queue_burst_round_robin_core fqbrr_checker u_fqbrr_checker (.*);

[dv/four_queue_burst_round_robin_core_tb.sv]
// Testbench for the four-queue burst round-robin core: directed and random traffic.
`timescale 1ns / 100ps
module four_queue_burst_round_robin_core_tb;

  localparam int QDEPTH      = 16;
  localparam int LANES       = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 135;

  typedef struct packed {
    fqbrr_pkg::status_t                status;
    logic [fqbrr_pkg::ID_W-1:0]        id;
    logic [fqbrr_pkg::TIME_W-1:0]      hold;
    logic [fqbrr_pkg::LANE_W-1:0]      lane;
    logic                              started;
  } outcome_t;

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_ready;
  logic                                in_command;
  logic [fqbrr_pkg::LANE_W-1:0]        in_arrive_lane;
  logic [fqbrr_pkg::ID_W-1:0]          in_car_id;
  logic [fqbrr_pkg::TIME_W-1:0]        in_hold_time;
  logic                                out_valid;
  logic                                out_ready;
  logic [1:0]                          out_status;
  logic [fqbrr_pkg::ID_W-1:0]          out_served_id;
  logic [fqbrr_pkg::TIME_W-1:0]        out_served_time;
  logic [fqbrr_pkg::LANE_W-1:0]        out_served_lane;
  logic                                out_turn_started;
  logic                                cfg_we;
  logic [fqbrr_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [fqbrr_pkg::CFG_DATA_W-1:0]    cfg_wdata;

  // lane model
  fqbrr_pkg::entry_t                   lane_fifo [LANES][QDEPTH];
  logic [3:0]                          fifo_rd [LANES];
  logic [3:0]                          fifo_wr [LANES];
  logic [4:0]                          fifo_fill [LANES];
  logic [fqbrr_pkg::LANE_W-1:0]        owner_lane;
  logic [fqbrr_pkg::LIMIT_W-1:0]       owner_grants;
  logic                                owner_live;
  logic [fqbrr_pkg::LIMIT_W-1:0]       grant_cap;

  outcome_t pending_outcomes [$];

  bit gaps_on;
  int mismatches;
  int quiet_cycles;
  int transfers;
  int grants;
  int new_turns;
  int drops;
  int empties;
  int settings_run;

  four_queue_burst_round_robin_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_arrive_lane   (in_arrive_lane),
    .in_car_id        (in_car_id),
    .in_hold_time     (in_hold_time),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_served_id    (out_served_id),
    .out_served_time  (out_served_time),
    .out_served_lane  (out_served_lane),
    .out_turn_started (out_turn_started),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic fqbrr_pkg::entry_t take_head(logic [fqbrr_pkg::LANE_W-1:0] lane);
    fqbrr_pkg::entry_t e;
    e = lane_fifo[lane][fifo_rd[lane]];
    fifo_rd[lane]   = fifo_rd[lane] + 1'b1;
    fifo_fill[lane] = fifo_fill[lane] - 1'b1;
    return e;
  endfunction

  function automatic outcome_t arbitrate_item(fqbrr_pkg::command_t cmd,
                                              logic [fqbrr_pkg::LANE_W-1:0] lane,
                                              logic [fqbrr_pkg::ID_W-1:0] id,
                                              logic [fqbrr_pkg::TIME_W-1:0] hold);
    outcome_t                       r;
    fqbrr_pkg::entry_t              e;
    logic [fqbrr_pkg::LIMIT_W-1:0]  cap;
    logic [fqbrr_pkg::LANE_W-1:0]   probe;
    bit                             found;
    r = '0;
    if (cmd == fqbrr_pkg::CMD_ARRIVE) begin
      if (fifo_fill[lane] >= QDEPTH) begin
        r.status = fqbrr_pkg::ST_FULL;
      end else begin
        lane_fifo[lane][fifo_wr[lane]] = '{car_id: id, hold_time: hold};
        fifo_wr[lane]   = fifo_wr[lane] + 1'b1;
        fifo_fill[lane] = fifo_fill[lane] + 1'b1;
        r.status = fqbrr_pkg::ST_ACCEPTED;
      end
    end else begin
      cap = (grant_cap == '0) ? fqbrr_pkg::LIMIT_W'(1) : grant_cap;
      if (owner_live && fifo_fill[owner_lane] != 0 && owner_grants < cap) begin
        e = take_head(owner_lane);
        owner_grants = owner_grants + 1'b1;
        r.status = fqbrr_pkg::ST_SERVED;
        r.id     = e.car_id;
        r.hold   = e.hold_time;
        r.lane   = owner_lane;
      end else begin
        probe = owner_live ? owner_lane + 1'b1 : owner_lane;
        found = 1'b0;
        for (int k = 0; k < LANES; k++) begin
          if (!found) begin
            if (fifo_fill[probe] != 0) found = 1'b1;
            else probe = probe + 1'b1;
          end
        end
        if (found) begin
          e = take_head(probe);
          owner_lane   = probe;
          owner_grants = fqbrr_pkg::LIMIT_W'(1);
          owner_live   = 1'b1;
          r.status  = fqbrr_pkg::ST_SERVED;
          r.id      = e.car_id;
          r.hold    = e.hold_time;
          r.lane    = probe;
          r.started = 1'b1;
        end else begin
          r.status = fqbrr_pkg::ST_EMPTY;
        end
      end
    end
    return r;
  endfunction

  // check results, predict transfers, track register writes
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{fqbrr_pkg::status_t'(out_status), out_served_id, out_served_time,
                out_served_lane, out_turn_started};
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result status %0d id %h time %h lane %0d turn %b",
                     $realtime, got.status, got.id, got.hold, got.lane, got.started);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.status !== want.status || got.id !== want.id || got.hold !== want.hold ||
              got.lane !== want.lane || got.started !== want.started) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: expected status %0d id %h time %h lane %0d turn %b, ",
                        "got status %0d id %h time %h lane %0d turn %b"}, $realtime,
                       want.status, want.id, want.hold, want.lane, want.started,
                       got.status, got.id, got.hold, got.lane, got.started);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = arbitrate_item(fqbrr_pkg::command_t'(in_command), in_arrive_lane,
                              in_car_id, in_hold_time);
        transfers++;
        case (want.status)
          fqbrr_pkg::ST_SERVED: begin
            grants++;
            if (want.started) new_turns++;
          end
          fqbrr_pkg::ST_FULL:  drops++;
          fqbrr_pkg::ST_EMPTY: empties++;
          default: ;
        endcase
        pending_outcomes.push_back(want);
      end
      if (cfg_we) begin
        case (fqbrr_pkg::cfg_reg_t'(cfg_index))
          fqbrr_pkg::REG_BURST_LIMIT: grant_cap = cfg_wdata;
          fqbrr_pkg::REG_START_LANE: begin
            owner_lane   = cfg_wdata[fqbrr_pkg::LANE_W-1:0];
            owner_grants = '0;
            owner_live   = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("four_queue_burst_round_robin_core: mismatch");
      $finish;
    end
  end

  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(fqbrr_pkg::command_t cmd, logic [fqbrr_pkg::LANE_W-1:0] lane,
                           logic [fqbrr_pkg::ID_W-1:0] id,
                           logic [fqbrr_pkg::TIME_W-1:0] hold);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_arrive_lane <= lane;
    in_car_id      <= id;
    in_hold_time   <= hold;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic program_phase(logic [fqbrr_pkg::LIMIT_W-1:0] cap,
                               logic [fqbrr_pkg::LANE_W-1:0] lane, bit move_start);
    cfg_we    <= 1'b1;
    cfg_index <= fqbrr_pkg::REG_BURST_LIMIT;
    cfg_wdata <= cap;
    @(posedge clk);
    if (move_start) begin
      cfg_index <= fqbrr_pkg::REG_START_LANE;
      cfg_wdata <= {(fqbrr_pkg::CFG_DATA_W - fqbrr_pkg::LANE_W)'($urandom_range(0, 63)),
                    lane};
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  task automatic test_first_turn_and_wrap();
    send_item(fqbrr_pkg::CMD_SERVE,  2'd2, 16'hFFFF, 8'hFF);
    send_item(fqbrr_pkg::CMD_ARRIVE, 2'd0, 16'h0000, 8'h00);
    send_item(fqbrr_pkg::CMD_ARRIVE, 2'd3, 16'hFFFF, 8'hFF);
    send_item(fqbrr_pkg::CMD_ARRIVE, 2'd3, 16'hAAAA, 8'h55);
    repeat (4) send_item(fqbrr_pkg::CMD_SERVE, 2'd0, 16'h0000, 8'h00);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i <= QDEPTH; i++)
      send_item(fqbrr_pkg::CMD_ARRIVE, 2'd1, 16'h5555 ^ fqbrr_pkg::ID_W'(i),
                ~fqbrr_pkg::TIME_W'(i));
  endtask

  task automatic test_random_phases();
    logic [fqbrr_pkg::LIMIT_W-1:0] cap_plan [8];
    logic [fqbrr_pkg::LANE_W-1:0]  lane_plan [8];
    int                            arrive_pct;
    logic [fqbrr_pkg::LANE_W-1:0]  busy_lane;
    cap_plan  = '{8'd1, 8'd0, 8'd2, 8'd3, 8'd255, 8'd5, 8'd4, 8'd2};
    lane_plan = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3};
    for (int p = 0; p < 8; p++) begin
      drain_results();
      if (p == 5) cap_plan[p] = fqbrr_pkg::LIMIT_W'($urandom_range(1, 16));
      gaps_on = (p != 7);
      program_phase(cap_plan[p], lane_plan[p], p % 3 != 2);
      arrive_pct = 40 + 15 * (p % 3);
      busy_lane  = fqbrr_pkg::LANE_W'($urandom_range(0, LANES - 1));
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_item($urandom_range(0, 99) < arrive_pct ? fqbrr_pkg::CMD_ARRIVE
                                                     : fqbrr_pkg::CMD_SERVE,
                  $urandom_range(0, 2) == 0 ? busy_lane
                                            : fqbrr_pkg::LANE_W'($urandom_range(0, 3)),
                  fqbrr_pkg::ID_W'($urandom), fqbrr_pkg::TIME_W'($urandom));
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_command     <= fqbrr_pkg::CMD_ARRIVE;
    in_arrive_lane <= '0;
    in_car_id      <= '0;
    in_hold_time   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= fqbrr_pkg::REG_BURST_LIMIT;
    cfg_wdata      <= '0;
    gaps_on        = 1'b1;
    for (int l = 0; l < LANES; l++) begin
      fifo_rd[l]   = '0;
      fifo_wr[l]   = '0;
      fifo_fill[l] = '0;
    end
    owner_lane   = '0;
    owner_grants = '0;
    owner_live   = 1'b0;
    grant_cap    = fqbrr_pkg::LIMIT_W'(1);
    settings_run = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_turn_and_wrap();
    test_full_queue();
    test_random_phases();
    drain_results();
    repeat (4) @(posedge clk);

    $display("Covered %0d transfers over %0d register settings: %0d grants, %0d new turns,",
             transfers, settings_run, grants, new_turns);
    $display("%0d arrivals dropped on a full queue, %0d serves with every queue empty.",
             drops, empties);
    if (mismatches == 0)
      $display("four_queue_burst_round_robin_core: match");
    else
      $display("four_queue_burst_round_robin_core: mismatch");
    $finish;
  end

endmodule
